// ===== design/ptc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared widths, register indexes and constants for the pressure and
// temperature compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int TEMP_W  = 19;
    localparam int PRES_W  = 24;
    localparam int ADDR_W  = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int STAGES  = 7;

    localparam logic [ADDR_W-1:0] REG_C1 = 3'd0;
    localparam logic [ADDR_W-1:0] REG_C2 = 3'd1;
    localparam logic [ADDR_W-1:0] REG_C3 = 3'd2;
    localparam logic [ADDR_W-1:0] REG_C4 = 3'd3;
    localparam logic [ADDR_W-1:0] REG_C5 = 3'd4;
    localparam logic [ADDR_W-1:0] REG_C6 = 3'd5;

    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;
    localparam logic signed [PRES_W-1:0] PRES_MAX  = 24'sh7FFFFF;
    localparam logic signed [PRES_W-1:0] PRES_MIN  = 24'sh800000;

endpackage
`default_nettype wire

// ===== design/pressure_temperature_compensation.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// First-order calibration of raw temperature and pressure conversions with
// six factory coefficients; results scaled by 100, pressure saturated.
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  s_axis    in         tdata: raw_temperature, raw_pressure
//  m_axis    out        tdata: temperature_centi, pressure_native
//                       tuser: pressure_saturated
//  cfg       in         index, 16-bit coefficient
//
//  One transfer per cycle in and out while m_axis is ready; the stages are dt,
//  three temperature products, OFF/SENS, two split D1*SENS partial products,
//  product merge, offset subtract and shift/saturate into the output register.
//  Reset clears valid bits and coefficients. A stall at m_axis holds the
//  output; upstream stages keep filling bubbles until the pipe is full.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [23:0] raw_temperature, [47:24] raw_pressure
    input  wire  [ptc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [18:0] temperature_centi, [42:19] pressure_native, [47:43] zero
    output logic [ptc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] pressure_saturated
    output logic [0:0]                        m_axis_tuser,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [ptc_pkg::ADDR_W-1:0]        i_cfg_addr,
    input  wire  [ptc_pkg::COEF_W-1:0]        i_cfg_data
);
    import ptc_pkg::*;

    // coefficients
    logic [COEF_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    // stage valids and advance enables
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_adv;

    // stage data
    logic signed [24:0]        r_s1_dt;
    logic [RAW_W-1:0]          r_s1_d1;
    logic signed [41:0]        r_s2_prod_c3, r_s2_prod_c4, r_s2_prod_c6;
    logic [RAW_W-1:0]          r_s2_d1;
    logic signed [34:0]        r_s3_sens;
    logic signed [35:0]        r_s3_off;
    logic signed [TEMP_W-1:0]  r_s3_temp;
    logic [RAW_W-1:0]          r_s3_d1;
    logic [41:0]               r_s4_pp_lo;
    logic signed [41:0]        r_s4_pp_hi;
    logic signed [35:0]        r_s4_off;
    logic signed [TEMP_W-1:0]  r_s4_temp;
    logic [38:0]               r_s5_prod_hi;
    logic signed [35:0]        r_s5_off;
    logic signed [TEMP_W-1:0]  r_s5_temp;
    logic signed [39:0]        r_s6_diff;
    logic signed [TEMP_W-1:0]  r_s6_temp;
    logic signed [TEMP_W-1:0]  r_out_temp;
    logic signed [PRES_W-1:0]  r_out_pres;
    logic                      r_out_sat;

    logic signed [41:0]        w_c3_sh, w_c4_sh, w_c6_sh;
    logic [59:0]               w_prod;
    logic [24:0]               w_pres_wide;
    logic                      w_pres_sat;

    always_comb begin
        w_adv[STAGES-1] = !r_vld[STAGES-1] || m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign s_axis_tready = w_adv[0];
    assign o_cfg_ready   = 1'b1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_addr)
                REG_C1:  r_c1 <= i_cfg_data;
                REG_C2:  r_c2 <= i_cfg_data;
                REG_C3:  r_c3 <= i_cfg_data;
                REG_C4:  r_c4 <= i_cfg_data;
                REG_C5:  r_c5 <= i_cfg_data;
                REG_C6:  r_c6 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage combinational terms
    assign w_c3_sh = r_s2_prod_c3 >>> 7;
    assign w_c4_sh = r_s2_prod_c4 >>> 6;
    assign w_c6_sh = r_s2_prod_c6 >>> 23;
    assign w_prod  = {r_s4_pp_hi, 18'd0} + {18'd0, r_s4_pp_lo};
    assign w_pres_wide = r_s6_diff[39:15];
    assign w_pres_sat  = w_pres_wide[24] != w_pres_wide[23];

    // 1: dt
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s1_dt <= $signed({1'b0, s_axis_tdata[RAW_W-1:0]})
                     - $signed({1'b0, r_c5, 8'h00});
            r_s1_d1 <= s_axis_tdata[2*RAW_W-1:RAW_W];
        end
    end

    // 2: dt products
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s2_prod_c3 <= r_s1_dt * $signed({1'b0, r_c3});
            r_s2_prod_c4 <= r_s1_dt * $signed({1'b0, r_c4});
            r_s2_prod_c6 <= r_s1_dt * $signed({1'b0, r_c6});
            r_s2_d1      <= r_s1_d1;
        end
    end

    // 3: SENS, OFF, temperature
    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_s3_sens <= $signed({3'b000, r_c1, 16'h0000}) + $signed(w_c3_sh[34:0]);
            r_s3_off  <= $signed({3'b000, r_c2, 17'd0}) + $signed(w_c4_sh[35:0]);
            r_s3_temp <= $signed(w_c6_sh[TEMP_W-1:0]) + TEMP_BASE;
            r_s3_d1   <= r_s2_d1;
        end
    end

    // 4: D1*SENS as two partial products
    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_s4_pp_lo <= r_s3_d1 * r_s3_sens[17:0];
            r_s4_pp_hi <= $signed({1'b0, r_s3_d1}) * $signed(r_s3_sens[34:18]);
            r_s4_off   <= r_s3_off;
            r_s4_temp  <= r_s3_temp;
        end
    end

    // 5: merge, floor by 2^21
    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_s5_prod_hi <= w_prod[59:21];
            r_s5_off     <= r_s4_off;
            r_s5_temp    <= r_s4_temp;
        end
    end

    // 6: subtract OFF
    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_s6_diff <= $signed({r_s5_prod_hi[38], r_s5_prod_hi})
                       - $signed({{4{r_s5_off[35]}}, r_s5_off});
            r_s6_temp <= r_s5_temp;
        end
    end

    // 7: floor by 2^15, saturate
    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_out_temp <= r_s6_temp;
            r_out_sat  <= w_pres_sat;
            if (w_pres_sat) begin
                r_out_pres <= w_pres_wide[24] ? PRES_MIN : PRES_MAX;
            end else begin
                r_out_pres <= $signed(w_pres_wide[PRES_W-1:0]);
            end
        end
    end

    assign m_axis_tvalid = r_vld[STAGES-1];
    assign m_axis_tdata  = {5'b00000, r_out_pres, r_out_temp};
    assign m_axis_tuser  = r_out_sat;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("stalled result dropped");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        (r_out_pres == PRES_MAX || r_out_pres == PRES_MIN))
        else $error("saturation flag without clipped pressure");

endmodule
`default_nettype wire
